// ----- hw/rtl/qnl_pkg.sv -----
// Shared types, widths and codes for the quaternion nlerp / lerp pipeline.
// No dependencies; every other file imports this package.
package qnl_pkg;

   localparam int LANES  = 4;
   localparam int VAL_W  = 32;
   localparam int T_W    = 17;
   localparam int CNT_W  = 3;
   localparam int FRAC_W = 16;
   localparam int MAG_W  = 32;
   localparam int U_W    = 30;
   localparam int SQ_W   = 60;
   localparam int N_W    = 62;
   localparam int ROOT_W = 31;
   localparam int NUM_W  = 47;
   localparam int QUO_W  = 17;
   localparam int SHW    = 5;

   localparam logic [SHW-1:0]   NORM_MSB = 5'd29;
   localparam logic [T_W-1:0]   ONE_Q16  = 17'h10000;
   localparam logic [CNT_W-1:0] CNT_FULL = 3'd4;
   localparam logic             FUNC_LINEAR = 1'b0;
   localparam logic             FUNC_ROT    = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_COUNT = 2'd1,
      ST_ZERO  = 2'd2,
      ST_OVF   = 2'd3
   } status_type;

   typedef struct packed {
      logic                        func;
      logic [CNT_W-1:0]            cnt;
      logic [LANES-1:0][VAL_W-1:0] f;
      logic [LANES-1:0][VAL_W-1:0] g;
   } req_type;

   typedef struct packed {
      logic                        rot;
      status_type                  status;
      logic [LANES-1:0][VAL_W-1:0] lin;
      logic [LANES-1:0]            neg;
   } carry_type;

   typedef struct packed {
      carry_type                 c;
      logic [LANES-1:0][U_W-1:0] u;
   } side_type;

endpackage

// ----- hw/rtl/qnl_blend.sv -----
// Front end: hemisphere test, per-component interpolation, saturation, magnitudes.
// Six register stages; depends on qnl_pkg.
module qnl_blend (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  qnl_pkg::req_type                          in_req,
   input  logic [qnl_pkg::T_W-1:0]                   in_t,
   output logic                                      out_valid,
   output qnl_pkg::carry_type                        out_carry,
   output logic [qnl_pkg::LANES-1:0][qnl_pkg::MAG_W-1:0] out_mag
);
   import qnl_pkg::*;

   localparam int PROD_W = 2 * VAL_W;
   localparam int DOT_W  = PROD_W + 2;
   localparam int D_W    = VAL_W + 2;
   localparam int P_W    = D_W + T_W + 1;
   localparam int E_W    = P_W - FRAC_W + 1;

   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   req_type           req1_ff, req2_ff, req3_ff, req4_ff, req5_ff;
   logic [T_W-1:0]    t1_ff, t2_ff, t3_ff;
   logic signed [PROD_W-1:0] prod_in [LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [D_W-1:0]    d_in [LANES];
   logic signed [D_W-1:0]    d_ff [LANES];
   logic signed [P_W-1:0]    p_in [LANES];
   logic signed [P_W-1:0]    p_ff [LANES];
   logic signed [P_W-1:0]    rnd  [LANES];
   logic signed [E_W-1:0]    e_in [LANES];
   logic signed [E_W-1:0]    e_ff [LANES];
   logic signed [E_W-1:0]    abs_e [LANES];
   logic signed [DOT_W-1:0]  dot;
   logic signed [D_W-1:0]    gsel;
   logic                     flip;
   logic [CNT_W-1:0]         cnt_eff;
   logic                     ovf;
   carry_type                carry_in, carry_ff;
   logic [LANES-1:0][MAG_W-1:0] mag_in, mag_ff;

   localparam logic signed [E_W-1:0] SAT_HI = E_W'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
   localparam logic signed [E_W-1:0] SAT_LO = -SAT_HI - E_W'(1);
   localparam logic signed [P_W-1:0] HALF   = P_W'(1) <<< (FRAC_W - 1);

   always_comb begin
      dot = '0;
      for (int k = 0; k < LANES; k++) begin
         prod_in[k] = $signed(req1_ff.f[k]) * $signed(req1_ff.g[k]);
         dot = dot + DOT_W'(prod_ff[k]);
      end
      flip = (req2_ff.func == FUNC_ROT) && (dot < 0);
      for (int k = 0; k < LANES; k++) begin
         gsel    = flip ? -D_W'($signed(req2_ff.g[k])) : D_W'($signed(req2_ff.g[k]));
         d_in[k] = gsel - D_W'($signed(req2_ff.f[k]));
         p_in[k] = d_ff[k] * $signed({1'b0, t3_ff});
         rnd[k]  = p_ff[k] + HALF;
         e_in[k] = E_W'($signed(req4_ff.f[k])) + E_W'($signed(rnd[k][P_W-1:FRAC_W]));
      end
   end

   always_comb begin
      cnt_eff  = (req5_ff.cnt > CNT_FULL) ? CNT_FULL : req5_ff.cnt;
      ovf      = 1'b0;
      carry_in = '0;
      carry_in.rot = (req5_ff.func == FUNC_ROT);
      for (int k = 0; k < LANES; k++) begin
         abs_e[k]          = (e_ff[k] < 0) ? -e_ff[k] : e_ff[k];
         mag_in[k]         = abs_e[k][MAG_W-1:0];
         carry_in.neg[k]   = (e_ff[k] < 0);
         carry_in.lin[k]   = '0;
         if (!carry_in.rot && (CNT_W'(k) < cnt_eff)) begin
            if (e_ff[k] > SAT_HI) begin
               carry_in.lin[k] = SAT_HI[VAL_W-1:0];
               ovf = 1'b1;
            end else if (e_ff[k] < SAT_LO) begin
               carry_in.lin[k] = SAT_LO[VAL_W-1:0];
               ovf = 1'b1;
            end else begin
               carry_in.lin[k] = e_ff[k][VAL_W-1:0];
            end
         end
      end
      if (carry_in.rot) begin
         carry_in.status = (cnt_eff == CNT_FULL) ? ST_OK : ST_COUNT;
      end else begin
         carry_in.status = ovf ? ST_OVF : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req1_ff  <= in_req;
         t1_ff    <= in_t;
         req2_ff  <= req1_ff;
         t2_ff    <= t1_ff;
         prod_ff  <= prod_in;
         req3_ff  <= req2_ff;
         t3_ff    <= t2_ff;
         d_ff     <= d_in;
         req4_ff  <= req3_ff;
         p_ff     <= p_in;
         req5_ff  <= req4_ff;
         e_ff     <= e_in;
         carry_ff <= carry_in;
         mag_ff   <= mag_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_carry = carry_ff;
   assign out_mag   = mag_ff;

endmodule

// ----- hw/rtl/qnl_scale.sv -----
// Block scaling of the magnitudes into [2^29, 2^30) and the squared norm.
// Five register stages; depends on qnl_pkg.
module qnl_scale (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic                                          in_valid,
   input  qnl_pkg::carry_type                            in_carry,
   input  logic [qnl_pkg::LANES-1:0][qnl_pkg::MAG_W-1:0] in_mag,
   output logic                                          out_valid,
   output qnl_pkg::side_type                             out_side,
   output logic [qnl_pkg::N_W-1:0]                       out_norm
);
   import qnl_pkg::*;

   logic                         v7_ff, v8_ff, v9_ff, v10_ff, v11_ff;
   carry_type                    c7_ff, c8_ff, c9_ff, c10_ff, c11_ff;
   logic [LANES-1:0][MAG_W-1:0]  mag7_ff, mag8_ff;
   logic [MAG_W-1:0]             mx_in, mx_ff;
   logic [SHW-1:0]               msb_in, msb_ff;
   carry_type                    c8_in;
   logic [LANES-1:0][U_W-1:0]    u_in, u9_ff, u10_ff, u11_ff;
   logic [LANES-1:0][SQ_W-1:0]   sq_in, sq_ff;
   logic [N_W-1:0]               n_in, n_ff;
   logic [MAG_W-1:0]             shifted;

   always_comb begin
      mx_in = in_mag[0];
      for (int k = 1; k < LANES; k++) begin
         if (in_mag[k] > mx_in) mx_in = in_mag[k];
      end
      msb_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (mx_ff[i]) msb_in = SHW'(i);
      end
      c8_in = c7_ff;
      if (c7_ff.rot && (c7_ff.status == ST_OK) && (mx_ff == '0)) c8_in.status = ST_ZERO;
      for (int k = 0; k < LANES; k++) begin
         if (msb_ff >= NORM_MSB) shifted = mag8_ff[k] >> (msb_ff - NORM_MSB);
         else                    shifted = mag8_ff[k] << (NORM_MSB - msb_ff);
         u_in[k]  = shifted[U_W-1:0];
         sq_in[k] = u9_ff[k] * u9_ff[k];
      end
      n_in = '0;
      for (int k = 0; k < LANES; k++) n_in = n_in + N_W'(sq_ff[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else if (en) begin
         v7_ff  <= in_valid;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c7_ff   <= in_carry;
         mag7_ff <= in_mag;
         mx_ff   <= mx_in;
         c8_ff   <= c8_in;
         mag8_ff <= mag7_ff;
         msb_ff  <= msb_in;
         c9_ff   <= c8_ff;
         u9_ff   <= u_in;
         c10_ff  <= c9_ff;
         u10_ff  <= u9_ff;
         sq_ff   <= sq_in;
         c11_ff  <= c10_ff;
         u11_ff  <= u10_ff;
         n_ff    <= n_in;
      end
   end

   assign out_valid  = v11_ff;
   assign out_side.c = c11_ff;
   assign out_side.u = u11_ff;
   assign out_norm   = n_ff;

endmodule

// ----- hw/rtl/qnl_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, floor result.
// Carries the side word alongside; depends on qnl_pkg.
module qnl_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  qnl_pkg::side_type           in_side,
   input  logic [qnl_pkg::N_W-1:0]     in_norm,
   output logic                        out_valid,
   output qnl_pkg::side_type           out_side,
   output logic [qnl_pkg::ROOT_W-1:0]  out_root
);
   import qnl_pkg::*;

   localparam int TW = 64;

   logic              v_d    [ROOT_W];
   side_type          side_d [ROOT_W];
   logic [N_W-1:0]    rem_d  [ROOT_W];
   logic [ROOT_W-1:0] root_d [ROOT_W];
   logic              v_ff    [ROOT_W];
   side_type          side_ff [ROOT_W];
   logic [N_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      localparam int BIT = ROOT_W - 1 - j;
      logic [TW-1:0] trial;
      logic          take;

      if (j == 0) begin : g_first
         assign v_d[j]    = in_valid;
         assign side_d[j] = in_side;
         assign rem_d[j]  = in_norm;
         assign root_d[j] = '0;
      end else begin : g_next
         assign v_d[j]    = v_ff[j-1];
         assign side_d[j] = side_ff[j-1];
         assign rem_d[j]  = rem_ff[j-1];
         assign root_d[j] = root_ff[j-1];
      end

      assign trial = (TW'(root_d[j]) << (BIT + 1)) | (TW'(1) << (2 * BIT));
      assign take  = TW'(rem_d[j]) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_d[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[j] <= side_d[j];
            rem_ff[j]  <= take ? rem_d[j] - trial[N_W-1:0] : rem_d[j];
            root_ff[j] <= take ? root_d[j] | (ROOT_W'(1) << BIT) : root_d[j];
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];

endmodule

// ----- hw/rtl/qnl_div.sv -----
// Rounded division of each scaled magnitude by the root, one quotient bit per stage.
// One setup stage and QUO_W restoring stages; depends on qnl_pkg.
module qnl_div (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic                                          in_valid,
   input  qnl_pkg::side_type                             in_side,
   input  logic [qnl_pkg::ROOT_W-1:0]                    in_root,
   output logic                                          out_valid,
   output qnl_pkg::carry_type                            out_carry,
   output logic [qnl_pkg::LANES-1:0][qnl_pkg::QUO_W-1:0] out_quo
);
   import qnl_pkg::*;

   logic                          v0_ff;
   carry_type                     c0_ff;
   logic [ROOT_W-1:0]             s0_ff;
   logic [LANES-1:0][NUM_W-1:0]   num_in, num_ff;

   logic                          v_d   [QUO_W];
   carry_type                     c_d   [QUO_W];
   logic [ROOT_W-1:0]             s_d   [QUO_W];
   logic [LANES-1:0][NUM_W-1:0]   rem_d [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   q_d   [QUO_W];
   logic                          v_ff   [QUO_W];
   carry_type                     c_ff   [QUO_W];
   logic [ROOT_W-1:0]             s_ff   [QUO_W];
   logic [LANES-1:0][NUM_W-1:0]   rem_ff [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   q_ff   [QUO_W];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         num_in[k] = {in_side.u[k], {FRAC_W{1'b0}}} + NUM_W'(in_root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c0_ff  <= in_side.c;
         s0_ff  <= in_root;
         num_ff <= num_in;
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int BIT = QUO_W - 1 - j;
      logic [NUM_W-1:0]            dv;
      logic [LANES-1:0][NUM_W-1:0] rem_in;
      logic [LANES-1:0][QUO_W-1:0] q_in;

      if (j == 0) begin : g_first
         assign v_d[j]   = v0_ff;
         assign c_d[j]   = c0_ff;
         assign s_d[j]   = s0_ff;
         assign rem_d[j] = num_ff;
         assign q_d[j]   = '0;
      end else begin : g_next
         assign v_d[j]   = v_ff[j-1];
         assign c_d[j]   = c_ff[j-1];
         assign s_d[j]   = s_ff[j-1];
         assign rem_d[j] = rem_ff[j-1];
         assign q_d[j]   = q_ff[j-1];
      end

      assign dv = NUM_W'(s_d[j]) << BIT;

      always_comb begin
         for (int k = 0; k < LANES; k++) begin
            if (rem_d[j][k] >= dv) begin
               rem_in[k] = rem_d[j][k] - dv;
               q_in[k]   = q_d[j][k] | (QUO_W'(1) << BIT);
            end else begin
               rem_in[k] = rem_d[j][k];
               q_in[k]   = q_d[j][k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_d[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            c_ff[j]   <= c_d[j];
            s_ff[j]   <= s_d[j];
            rem_ff[j] <= rem_in;
            q_ff[j]   <= q_in;
         end
      end
   end

   assign out_valid = v_ff[QUO_W-1];
   assign out_carry = c_ff[QUO_W-1];
   assign out_quo   = q_ff[QUO_W-1];

endmodule

// ----- hw/rtl/quaternion_nlerp_and_lerp.sv -----
// Quaternion nlerp and per-component lerp, signed Q16.16, one channel per word.
// Throughput: one word per cycle when not stalled; the 31-stage square root and 18-stage divider set depth.
// The pipeline stalls only when its last stage and the output register are both full.
// Reset (synchronous, active high) empties the pipeline and clears blend_factor to 0.
module quaternion_nlerp_and_lerp (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // count, from_0..from_3, to_0..to_3, zero pad
   input  logic [263:0] req_tdata,
   // func
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_0..out_3, status, zero pad
   output logic [135:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [16:0]  csr_data
);
   import qnl_pkg::*;

   localparam int OUT_PAD = 136 - LANES * VAL_W - 2;

   logic [T_W-1:0]              t_ff;
   logic [T_W-1:0]              t_eff;
   logic                        en;
   req_type                     req;
   logic                        blend_v, scale_v, sqrt_v, div_v;
   carry_type                   blend_c, div_c;
   logic [LANES-1:0][MAG_W-1:0] blend_mag;
   side_type                    scale_s, sqrt_s;
   logic [N_W-1:0]              scale_n;
   logic [ROOT_W-1:0]           sqrt_r;
   logic [LANES-1:0][QUO_W-1:0] div_q;
   logic                        rsp_v_ff, rsp_v_in;
   logic [LANES-1:0][VAL_W-1:0] res_in, res_ff;
   status_type                  st_ff;
   logic                        load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff <= '0;
      end else if (csr_valid) begin
         t_ff <= csr_data;
      end
   end

   assign t_eff = (t_ff > ONE_Q16) ? ONE_Q16 : t_ff;

   assign req.func = req_tuser[0];
   assign req.cnt  = req_tdata[CNT_W-1:0];
   for (genvar k = 0; k < LANES; k++) begin : g_unpack
      assign req.f[k] = req_tdata[CNT_W + k * VAL_W +: VAL_W];
      assign req.g[k] = req_tdata[CNT_W + (LANES + k) * VAL_W +: VAL_W];
   end

   assign load       = div_v && (!rsp_v_ff || rsp_tready);
   assign en         = !div_v || !rsp_v_ff || rsp_tready;
   assign req_tready = en;

   qnl_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_req    (req),
      .in_t      (t_eff),
      .out_valid (blend_v),
      .out_carry (blend_c),
      .out_mag   (blend_mag)
   );

   qnl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (blend_v),
      .in_carry  (blend_c),
      .in_mag    (blend_mag),
      .out_valid (scale_v),
      .out_side  (scale_s),
      .out_norm  (scale_n)
   );

   qnl_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (scale_v),
      .in_side   (scale_s),
      .in_norm   (scale_n),
      .out_valid (sqrt_v),
      .out_side  (sqrt_s),
      .out_root  (sqrt_r)
   );

   qnl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_v),
      .in_side   (sqrt_s),
      .in_root   (sqrt_r),
      .out_valid (div_v),
      .out_carry (div_c),
      .out_quo   (div_q)
   );

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if (!div_c.rot) begin
            res_in[k] = div_c.lin[k];
         end else if (div_c.status == ST_OK) begin
            res_in[k] = div_c.neg[k] ? -VAL_W'(div_q[k]) : VAL_W'(div_q[k]);
         end else begin
            res_in[k] = '0;
         end
      end
      if (load)            rsp_v_in = 1'b1;
      else if (rsp_tready) rsp_v_in = 1'b0;
      else                 rsp_v_in = rsp_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
         st_ff  <= div_c.status;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{OUT_PAD{1'b0}}, st_ff, res_ff};

endmodule

// ----- verif/tb.sv -----
// Testbench for quaternion_nlerp_and_lerp: directed and random channel words
// checked against a built-in fixed-point predictor. Depends on qnl_pkg and the RTL.
`timescale 1ns / 1ps

class blend_scoreboard;
   logic [135:0] pending_rsp[$];
   int           mismatches;
   int           checked;

   function void note_req(logic [135:0] rsp);
      pending_rsp = {pending_rsp, rsp};
   endfunction

   function void check_rsp(logic [135:0] got);
      logic [135:0] want;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected rsp %h", got);
         return;
      end
      want = pending_rsp.pop_front();
      checked++;
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("rsp %0d: status exp %0d got %0d", checked, want[129:128],
                     got[129:128]);
            for (int k = 0; k < 4; k++)
               $display("  out_%0d exp %h got %h", k, want[k*32 +: 32], got[k*32 +: 32]);
         end
      end
   endfunction
endclass

module tb;
   import qnl_pkg::*;

   localparam longint HI_LIM = 64'sd2147483647;
   localparam longint LO_LIM = -64'sd2147483648;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [263:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [16:0]  csr_data = '0;

   logic [16:0]  blend_t;
   int           send_idle_pct;
   int           recv_idle_pct;
   bit           hold_off;
   longint       cycles;
   int           words_sent;
   blend_scoreboard sb;

   quaternion_nlerp_and_lerp u_top (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("quaternion_nlerp_and_lerp: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_rsp(rsp_tdata);
         rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic longint fdiv(longint a, longint d);
      longint q;
      q = a / d;
      if (a % d != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint sat32(longint v, ref bit ovf);
      if (v > HI_LIM) begin
         ovf = 1;
         return HI_LIM;
      end
      if (v < LO_LIM) begin
         ovf = 1;
         return LO_LIM;
      end
      return v;
   endfunction

   function automatic longint blend_q16(longint f, longint g, longint t);
      longint d, q, r;
      d = g - f;
      q = fdiv(d, 65536);
      r = d - q * 65536;
      return f + q * t + ((r * t + 32768) / 65536);
   endfunction

   function automatic logic [63:0] root64(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [135:0] predict_blend(logic func, logic [2:0] cnt_in,
                                                  logic [3:0][31:0] fr, logic [3:0][31:0] tg);
      longint f[4], g[4], res[4], t, o;
      logic [63:0] mag[4], mx, n, s;
      logic signed [127:0] dot;
      int c, p, sh;
      bit ovf;
      status_type st;
      logic [135:0] w;
      t = blend_t > ONE_Q16 ? 65536 : blend_t;
      c = cnt_in > 4 ? 4 : cnt_in;
      ovf = 0;
      st = ST_OK;
      dot = 0;
      for (int k = 0; k < 4; k++) begin
         f[k] = longint'($signed(fr[k]));
         g[k] = longint'($signed(tg[k]));
         res[k] = 0;
      end
      if (func == FUNC_LINEAR) begin
         for (int k = 0; k < c; k++) res[k] = sat32(blend_q16(f[k], g[k], t), ovf);
         if (ovf) st = ST_OVF;
      end else if (c != 4) begin
         st = ST_COUNT;
      end else begin
         for (int k = 0; k < 4; k++) dot += 128'(f[k]) * 128'(g[k]);
         for (int k = 0; k < 4; k++) res[k] = blend_q16(f[k], dot < 0 ? -g[k] : g[k], t);
         mx = 0;
         for (int k = 0; k < 4; k++) begin
            mag[k] = res[k] < 0 ? -res[k] : res[k];
            if (mag[k] > mx) mx = mag[k];
         end
         if (mx == 0) begin
            st = ST_ZERO;
            for (int k = 0; k < 4; k++) res[k] = 0;
         end else begin
            p = 0;
            while ((mx >> p) > 1) p++;
            sh = p - 29;
            n = 0;
            for (int k = 0; k < 4; k++) begin
               mag[k] = sh >= 0 ? mag[k] >> sh : mag[k] << (-sh);
               n += mag[k] * mag[k];
            end
            s = root64(n);
            for (int k = 0; k < 4; k++) begin
               o = longint'((mag[k] * 65536 + s / 2) / s);
               res[k] = sat32(res[k] < 0 ? -o : o, ovf);
            end
            if (ovf) st = ST_OVF;
         end
      end
      w = '0;
      for (int k = 0; k < 4; k++) w[k*32 +: 32] = res[k][31:0];
      w[129:128] = st;
      return w;
   endfunction

   task automatic send_word(logic func, logic [2:0] cnt, logic [3:0][31:0] fr,
                            logic [3:0][31:0] tg);
      while (!hold_off && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {5'b0, tg, fr, cnt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_req(predict_blend(func, cnt, fr, tg));
      words_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_blend(logic [16:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      blend_t = v;
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(131072) - 65536;
         3: return 32'(0);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(int num);
      logic [3:0][31:0] fr, tg;
      logic func;
      logic [2:0] cnt;
      for (int i = 0; i < num; i++) begin
         for (int k = 0; k < 4; k++) begin
            fr[k] = rand_comp();
            tg[k] = $urandom_range(9) == 0 ? -fr[k] : rand_comp();
         end
         func = 1'($urandom_range(1));
         cnt = $urandom_range(9) == 0 ? 3'($urandom) : ($urandom_range(3) == 0 ?
               3'($urandom_range(1, 3)) : CNT_FULL);
         send_word(func, cnt, fr, tg);
      end
   endtask

   initial begin
      logic [3:0][31:0] a, b;
      logic [16:0] tv[6];
      tv = '{17'd0, 17'h1ffff, ONE_Q16, 17'd32768, 17'd1, 17'h10001};
      sb = new();
      blend_t = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: reset value of t, extremes, zero norm, short rotation
      a = {32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h0};
      b = {32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 32'h1};
      send_word(FUNC_LINEAR, CNT_FULL, a, b);
      send_word(FUNC_ROT, CNT_FULL, a, b);
      drain();
      write_blend(17'h1ffff);
      send_word(FUNC_LINEAR, CNT_FULL, a, b);
      send_word(FUNC_LINEAR, 3'd0, a, b);
      send_word(FUNC_LINEAR, 3'd2, a, b);
      send_word(FUNC_LINEAR, 3'd7, a, b);
      send_word(FUNC_ROT, 3'd3, a, b);
      send_word(FUNC_ROT, 3'd7, a, b);
      send_word(FUNC_ROT, CNT_FULL, '0, '0);
      drain();
      write_blend(17'd32768);
      send_word(FUNC_ROT, CNT_FULL, {4{32'h0001_0000}}, {4{32'hffff_0000}});
      send_word(FUNC_ROT, CNT_FULL, {32'h0, 32'h0, 32'h0, 32'h1}, {32'h0, 32'h0, 32'h0, 32'h1});
      send_word(FUNC_ROT, CNT_FULL, {4{32'h8000_0000}}, {4{32'h8000_0000}});
      send_word(FUNC_LINEAR, CNT_FULL, {4{32'h8000_0000}}, {4{32'h7fff_ffff}});
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         write_blend(ph == 5 ? 17'($urandom) : tv[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 81; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 81; end
            default: begin send_idle_pct = 38; recv_idle_pct = 38; end
         endcase
         send_random(250);
         drain();
      end
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         send_random(150);
      join
      drain();
      $display("sent %0d words over six blend settings and four idle mixes, %0d checked",
               words_sent, sb.checked);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
         $display("quaternion_nlerp_and_lerp: match");
      end else begin
         $display("quaternion_nlerp_and_lerp: mismatch");
      end
      $finish;
   end
endmodule
